// ===== src/tfw_pkg.sv =====
// Shared types, constants and the LFO sine evaluation for the triple-tap flanger.
// No dependencies; imported by the flanger top level.
package tfw_pkg;

  typedef logic signed [15:0] lfo_t;
  typedef logic [31:0]        phase_t;

  // Register map, one 32-bit word per register
  typedef enum logic {
    REG_DELAY = 1'b0,
    REG_MIX   = 1'b1
  } reg_idx_t;

  localparam int TAP_BASE  = 600;
  localparam int TAP_SWING = 120;
  localparam int NUM_TAPS  = 3;

  // Four samples' worth of phase per refresh at 0.45, 1.45 and 2.45 Hz, 48 kHz
  localparam phase_t LFO_INC [NUM_TAPS] = '{32'd161061, 32'd518975, 32'd876889};

  // round(32767 * sin(k*pi/64)), k = 0..32
  localparam logic [14:0] QUARTER_SINE [33] = '{
    15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,  15'd11039,
    15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519, 15'd20787, 15'd22005,
    15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245, 15'd28105, 15'd28898, 15'd29621,
    15'd30273, 15'd30851, 15'd31356, 15'd31785, 15'd32137, 15'd32413, 15'd32609, 15'd32728,
    15'd32767
  };

  // Quarter-wave lookup with 9-bit linear interpolation, mirrored per quadrant
  function automatic lfo_t sine_of(input phase_t phase);
    logic [1:0]  quad;
    logic [13:0] p;
    logic [14:0] q;
    logic [5:0]  idx;
    logic [8:0]  frac;
    logic [14:0] a;
    logic [14:0] b;
    logic [10:0] diff;
    logic [19:0] prod;
    logic [14:0] mag;
    quad = phase[31:30];
    p    = phase[29:16];
    q    = quad[0] ? (15'd16384 - {1'b0, p}) : {1'b0, p};
    idx  = q[14:9];
    frac = q[8:0];
    a    = '0;
    b    = '0;
    diff = '0;
    prod = '0;
    if (idx >= 6'd32) begin
      mag = QUARTER_SINE[6'd32];
    end else begin
      a    = QUARTER_SINE[idx];
      b    = QUARTER_SINE[idx + 6'd1];
      diff = 11'(b - a);
      prod = diff * frac;
      mag  = a + 15'(prod[19:9]);
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ===== src/triple_tap_flanger_widener.sv =====
// Triple-tap LFO flanger with a stereo widening delay on the right channel.
// Depends on tfw_pkg (sine evaluation, LFO increments, register map).

// One mono word in, one stereo word out. Words are taken one per clock with no
// gaps while the output is not stalled; the datapath is a five-register
// pipeline (input, LFO value, history read, products, output), and a stall at
// the output backs up through the pipeline only when every stage is full. The
// sample enters a history ring held in three identical copies, one per tap, so
// all three flanger taps are read in the same cycle; the right-channel delay
// line is a single memory written and read once per word. Neither memory needs
// a clearing pass after reset: a fill count per ring makes entries not yet
// written read as zero, so the block takes words from the first cycle after
// reset. The three sine LFOs step and refresh on every fourth word, starting
// with the first. Registers (APB, 32-bit words):
// 0x0 right delay in samples (13 bits, zero copies left to right, values at or
// beyond the delay depth wrap), 0x4 wet share of the mix in 1/65536 units.
// Write registers only while no word is in flight.
module triple_tap_flanger_widener
  import tfw_pkg::*;
#(
  parameter int HISTORY_DEPTH = 1024,
  parameter int DELAY_DEPTH   = 8192,
  parameter int SAMPLE_WIDTH  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_out,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int DW = $clog2(DELAY_DEPTH);

  localparam logic [HW-1:0] HIST_LAST  = HW'(HISTORY_DEPTH - 1);
  localparam logic [HW:0]   HIST_FULL  = (HW+1)'(HISTORY_DEPTH);
  localparam logic [HW+1:0] HIST_WRAP  = (HW+2)'(HISTORY_DEPTH);
  localparam logic [HW+1:0] HIST_BACK  = (HW+2)'(HISTORY_DEPTH - TAP_BASE);
  localparam logic [DW-1:0] DLY_LAST   = DW'(DELAY_DEPTH - 1);
  localparam logic [DW:0]   DLY_FULL   = (DW+1)'(DELAY_DEPTH);
  localparam logic [DW:0]   DLY_WRAP   = (DW+1)'(DELAY_DEPTH);
  localparam logic signed [7:0] SWING  = 8'(TAP_SWING);

  // Reduce a raw delay setting modulo the delay depth; at most eight subtracts
  function automatic logic [DW-1:0] wrap_delay(input logic [12:0] v);
    logic [16:0] r;
    r = {4'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 17'(DELAY_DEPTH)) begin
        r = r - 17'(DELAY_DEPTH);
      end
    end
    return r[DW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [12:0]   delay_raw_r;
  logic [DW-1:0] delay_r;
  logic [15:0]   mix_r;
  logic          cfg_wr;
  reg_idx_t      cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_raw_r <= '0;
      delay_r     <= '0;
      mix_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DELAY: begin
          delay_raw_r <= pwdata[12:0];
          delay_r     <= wrap_delay(pwdata[12:0]);
        end
        REG_MIX: mix_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DELAY: prdata = {19'b0, delay_raw_r};
      REG_MIX:   prdata = {16'b0, mix_r};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic adv1, adv2, adv3, adv4, adv5, take;

  assign adv5     = s5_vld_r && !out_stall;
  assign adv4     = s4_vld_r && (!s5_vld_r || adv5);
  assign adv3     = s3_vld_r && (!s4_vld_r || adv4);
  assign adv2     = s2_vld_r && (!s3_vld_r || adv3);
  assign adv1     = s1_vld_r && (!s2_vld_r || adv2);
  assign in_stall = s1_vld_r && !adv1;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= take | (s1_vld_r & ~adv1);
      s2_vld_r <= adv1 | (s2_vld_r & ~adv2);
      s3_vld_r <= adv2 | (s3_vld_r & ~adv3);
      s4_vld_r <= adv3 | (s4_vld_r & ~adv4);
      s5_vld_r <= adv4 | (s5_vld_r & ~adv5);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: take the word, write history, step the LFO phases
  // ---------------------------------------------------------------------------
  logic [HW-1:0]   hidx_r;
  logic [HW:0]     hfill_r;
  logic [HW-1:0]   hidx_nxt;
  logic [HW:0]     hfill_nxt;
  logic [1:0]      hold_r;
  phase_t          phase_r [NUM_TAPS];
  lfo_t            lfo_value_r [NUM_TAPS];
  lfo_t            sine [NUM_TAPS];

  logic signed [SW-1:0] s1_x_r;
  logic [HW-1:0]        s1_hidx_r;
  logic [HW:0]          s1_hfill_r;
  logic                 s1_refresh_r;

  assign hidx_nxt  = (hidx_r == HIST_LAST) ? '0 : hidx_r + 1'b1;
  assign hfill_nxt = (hfill_r == HIST_FULL) ? hfill_r : hfill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hidx_r  <= '0;
      hfill_r <= '0;
      hold_r  <= '0;
      for (int j = 0; j < NUM_TAPS; j++) begin
        phase_r[j]     <= '0;
        lfo_value_r[j] <= '0;
      end
    end else begin
      if (take) begin
        hidx_r  <= hidx_nxt;
        hfill_r <= hfill_nxt;
        hold_r  <= hold_r - 2'd1;
        if (hold_r == 2'd0) begin
          for (int j = 0; j < NUM_TAPS; j++) begin
            phase_r[j] <= phase_r[j] + LFO_INC[j];
          end
        end
      end
      // latch the refreshed sine as the held value for the next three words
      if (adv1 && s1_refresh_r) begin
        for (int j = 0; j < NUM_TAPS; j++) begin
          lfo_value_r[j] <= sine[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x_r       <= in_sample_in;
      s1_hidx_r    <= hidx_nxt;
      s1_hfill_r   <= hfill_nxt;
      s1_refresh_r <= (hold_r == 2'd0);
    end
  end

  // phase_r always holds the phase of the newest word, which is the one in stage 1
  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      sine[j] = sine_of(phase_r[j]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: tap offsets and history addresses
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s2_x_r;
  logic [HW-1:0]        s2_hidx_r;
  logic [HW:0]          s2_hfill_r;
  lfo_t                 s2_lfo_r [NUM_TAPS];

  logic signed [23:0]   swing_prod [NUM_TAPS];
  logic [8:0]           tap_off [NUM_TAPS];
  logic [HW+1:0]        tap_sum [NUM_TAPS];
  logic [HW+1:0]        tap_wrapped [NUM_TAPS];
  logic [HW-1:0]        tap_pos [NUM_TAPS];
  logic                 tap_hit [NUM_TAPS];

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_x_r     <= s1_x_r;
      s2_hidx_r  <= s1_hidx_r;
      s2_hfill_r <= s1_hfill_r;
      for (int j = 0; j < NUM_TAPS; j++) begin
        s2_lfo_r[j] <= s1_refresh_r ? sine[j] : lfo_value_r[j];
      end
    end
  end

  // offset = floor(lfo * 120 / 32768), in -120..119
  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      swing_prod[j]  = s2_lfo_r[j] * SWING;
      tap_off[j]     = swing_prod[j][23:15];
      tap_sum[j]     = {2'b0, s2_hidx_r} + HIST_BACK
                       + {{(HW-7){tap_off[j][8]}}, tap_off[j]};
      tap_wrapped[j] = (tap_sum[j] >= HIST_WRAP) ? tap_sum[j] - HIST_WRAP : tap_sum[j];
      tap_pos[j]     = tap_wrapped[j][HW-1:0];
      // entries beyond the fill point have never been written: read as zero
      tap_hit[j]     = {1'b0, tap_pos[j]} < s2_hfill_r;
    end
  end

  // ---------------------------------------------------------------------------
  // History ring: one copy per tap, each written with every word
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] tap_data_r [NUM_TAPS];

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_hist
    logic [SW-1:0] hist_mem [HISTORY_DEPTH];

    always_ff @(posedge clk) begin
      if (take) begin
        hist_mem[hidx_r] <= in_sample_in;
      end
      if (adv2) begin
        tap_data_r[g] <= hist_mem[tap_pos[g]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: tap sum and mix products
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s3_x_r;
  logic                 s3_hit_r [NUM_TAPS];
  logic signed [SW+1:0] wet_sum;
  logic [16:0]          dry_weight;
  logic signed [SW+17:0] p_dry_nxt;
  logic signed [SW+18:0] p_wet_nxt;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_x_r <= s2_x_r;
      for (int j = 0; j < NUM_TAPS; j++) begin
        s3_hit_r[j] <= tap_hit[j];
      end
    end
  end

  always_comb begin
    wet_sum = '0;
    for (int j = 0; j < NUM_TAPS; j++) begin
      if (s3_hit_r[j]) begin
        wet_sum = wet_sum + (SW+2)'(tap_data_r[j]);
      end
    end
    dry_weight = 17'h10000 - {1'b0, mix_r};
    p_dry_nxt  = s3_x_r * $signed({1'b0, dry_weight});
    p_wet_nxt  = wet_sum * $signed({1'b0, mix_r});
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round, saturate, delay line access
  // ---------------------------------------------------------------------------
  logic signed [SW+17:0] p_dry_r;
  logic signed [SW+18:0] p_wet_r;
  logic signed [SW+19:0] mix_acc;
  logic [SW+19:0]        mix_rnd;
  logic [SW+2:0]         mix_q;
  logic [SW-1:0]         left;

  always_ff @(posedge clk) begin
    if (adv3) begin
      p_dry_r <= p_dry_nxt;
      p_wet_r <= p_wet_nxt;
    end
  end

  // (2*x*(65536-mix) - sum*mix) / 2^17, round half up, then clamp
  always_comb begin
    mix_acc = $signed({p_dry_r[SW+17], p_dry_r, 1'b0}) - $signed({p_wet_r[SW+18], p_wet_r});
    mix_rnd = mix_acc + (SW+20)'(65536);
    mix_q   = mix_rnd[SW+19:17];
    if (mix_q[SW+2:SW-1] == '0 || mix_q[SW+2:SW-1] == '1) begin
      left = mix_q[SW-1:0];
    end else if (mix_q[SW+2]) begin
      left = {1'b1, {(SW-1){1'b0}}};
    end else begin
      left = {1'b0, {(SW-1){1'b1}}};
    end
  end

  logic [DW-1:0] dwi_r;
  logic [DW:0]   dfill_r;
  logic [DW:0]   d_back;
  logic [DW-1:0] d_rd;
  logic          d_hit;

  // Every earlier word has already passed this stage, so the fill count is exact
  always_comb begin
    d_back = {1'b0, dwi_r} - {1'b0, delay_r};
    if (dwi_r < delay_r) begin
      d_back = d_back + DLY_WRAP;
    end
    d_rd  = d_back[DW-1:0];
    d_hit = dfill_r >= {1'b0, delay_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwi_r   <= '0;
      dfill_r <= '0;
    end else if (adv4) begin
      dwi_r   <= (dwi_r == DLY_LAST) ? '0 : dwi_r + 1'b1;
      dfill_r <= (dfill_r == DLY_FULL) ? dfill_r : dfill_r + 1'b1;
    end
  end

  logic [SW-1:0] dly_mem [DELAY_DEPTH];
  logic [SW-1:0] dly_data_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      dly_mem[dwi_r] <= left;
      dly_data_r     <= dly_mem[d_rd];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: output word
  // ---------------------------------------------------------------------------
  logic [SW-1:0] s5_left_r;
  logic          s5_dzero_r;
  logic          s5_dhit_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      s5_left_r  <= left;
      s5_dzero_r <= (delay_r == '0);
      s5_dhit_r  <= d_hit;
    end
  end

  assign out_valid     = s5_vld_r;
  assign out_left_out  = s5_left_r;
  assign out_right_out = s5_dzero_r ? s5_left_r : (s5_dhit_r ? dly_data_r : '0);

endmodule

// ===== src/tfw_checker.sv =====
// Port-level checker for the triple-tap flanger, with its bind to the top level.
// Depends only on the top level's ports.
module tfw_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [SAMPLE_WIDTH-1:0] in_sample_in,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_left_out,
  input logic [SAMPLE_WIDTH-1:0] out_right_out,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic [2:0]              paddr,
  input logic [31:0]             pwdata,
  input logic [31:0]             prdata,
  input logic                    pready
);

  logic [12:0] sh_delay_r;
  logic [15:0] sh_mix_r;

  // shadow the registers from completed writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_delay_r <= '0;
      sh_mix_r   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        sh_mix_r <= pwdata[15:0];
      end else begin
        sh_delay_r <= pwdata[12:0];
      end
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("output word changed under stall");

  // the pipeline never refuses input while the output side can drain
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output drains");

  // reads return what was last written
  a_mix_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && paddr[2] |-> prdata == {16'h0, sh_mix_r})
    else $error("mix register readback mismatch");

  a_delay_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && !paddr[2] |-> prdata == {19'h0, sh_delay_r})
    else $error("delay register readback mismatch");

  // nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind triple_tap_flanger_widener tfw_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_tfw_checker (.*);
